// ===== design/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/prgau_pkg.sv =====
// shared constants and types of the pagerank gather/apply unit
package prgau_pkg;

    localparam int unsigned VertexCountDefault  = 65536;
    localparam int unsigned RankFracDefault     = 32;
    localparam int unsigned DegreeBitsDefault   = 20;
    localparam int unsigned VidBits             = 16;
    localparam int unsigned DegBits             = 20;
    localparam int unsigned RankBits            = 48;
    localparam int unsigned AccBits             = 56;
    localparam int unsigned CountBits           = 32;
    localparam int unsigned CfgBits             = 32;
    localparam logic [CfgBits-1:0] ResetProbDefault = 32'd644245094;
    localparam logic [CfgBits-1:0] AccuracyDefault  = 32'd42950;

    localparam logic [1:0] RegResetProb = 2'd0;
    localparam logic [1:0] RegAccuracy  = 2'd1;

    localparam logic FuncGather = 1'b0;
    localparam logic FuncApply  = 1'b1;

    // divider request
    typedef struct packed {
        logic                start;
        logic [AccBits-1:0]  dividend;
        logic [DegBits-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [AccBits-1:0]  quotient;
    } div_rsp_t;

endpackage

// ===== design/prgau_if.sv =====
// valid/ready channel interfaces of the pagerank gather/apply unit
interface prgau_in_if
    import prgau_pkg::*;
(
    input logic clk
);
    logic               valid;
    logic               ready;
    logic               func;
    logic [VidBits-1:0] source_vertex;
    logic [DegBits-1:0] source_out_degree;
    logic [VidBits-1:0] target_vertex;
    logic [DegBits-1:0] target_out_degree;

    modport source (output valid, func, source_vertex, source_out_degree, target_vertex,
                    target_out_degree, input ready);
    modport sink (input valid, func, source_vertex, source_out_degree, target_vertex,
                  target_out_degree, output ready);
endinterface

interface prgau_out_if
    import prgau_pkg::*;
(
    input logic clk
);
    logic                 valid;
    logic                 ready;
    logic [VidBits-1:0]   updated_vertex;
    logic [RankBits-1:0]  new_rank;
    logic [RankBits-1:0]  residual;
    logic                 reschedule;
    logic [CountBits-1:0] update_count;

    modport source (output valid, updated_vertex, new_rank, residual, reschedule, update_count,
                    input ready);
    modport sink (input valid, updated_vertex, new_rank, residual, reschedule, update_count,
                  output ready);
endinterface

// ===== design/prgau_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module prgau_divider
    import prgau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int unsigned CntBits = $clog2(AccBits + 1);

    logic [AccBits-1:0] quo_reg;
    logic [DegBits:0]   rem_reg;
    logic [DegBits-1:0] dvs_reg;
    logic [CntBits-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DegBits:0]   shifted;
    logic [DegBits:0]   diff;

    assign shifted = {rem_reg[DegBits-1:0], quo_reg[AccBits-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntBits'(AccBits);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntBits'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DegBits])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[AccBits-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[AccBits-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/pagerank_gather_apply_unit.sv =====
// top level: vertex memories, gather accumulator and apply sequencer
// an apply reads, multiplies, sums and divides (no divide with zero out-degree), then waits for the output register
// throughput: one item at a time; no new input is taken until the current gather or apply is done,
// and the bit-serial divider, skipped with zero degree, sets the rate
// after reset a clearing pass over every vertex address initializes the memories
// no input is taken during that pass; configuration registers reset to their defaults
module pagerank_gather_apply_unit
    import prgau_pkg::*;
#(
    parameter int unsigned VERTEX_COUNT = VertexCountDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    prgau_in_if.sink           in_ch,
    prgau_out_if.source        out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [CfgBits-1:0] pwdata,
    output logic [CfgBits-1:0] prdata,
    output logic               pready
);

    localparam int unsigned AddrBits = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam logic [RankBits-1:0] RankOne = RankBits'(1) << RankFracDefault;
    localparam logic [RankBits-1:0] RankMax = '1;
    localparam logic [AccBits-1:0]  AccMax  = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_GDIV, S_GWAIT, S_AMUL, S_ASUM, S_ADIV, S_AWAIT, S_OUT
    } state_t;

    state_t state_reg;

    logic [RankBits-1:0]  rank_mem [VERTEX_COUNT];
    logic [RankBits-1:0]  last_mem [VERTEX_COUNT];
    logic [CountBits-1:0] cnt_mem  [VERTEX_COUNT];

    logic [CfgBits-1:0]   restart_prob_reg;
    logic [CfgBits-1:0]   accuracy_reg;
    logic [AccBits-1:0]   acc_reg;
    logic [AddrBits-1:0]  clr_reg;
    logic                 func_reg;
    logic [AddrBits-1:0]  addr_reg;
    logic [VidBits-1:0]   vid_reg;
    logic [DegBits-1:0]   deg_reg;
    logic [RankBits-1:0]  rank_rd_reg;
    logic [RankBits-1:0]  last_rd_reg;
    logic [CountBits-1:0] cnt_rd_reg;
    logic [AccBits-1:0]   prod_hi_reg;
    logic [CfgBits-1:0]   prod_lo_reg;
    logic [RankBits-1:0]  rank_new_reg;
    logic [CountBits-1:0] res_cnt_reg;
    logic [RankBits-1:0]  res_resid_reg;
    logic                 res_resched_reg;
    logic                 out_valid_reg;
    logic [VidBits-1:0]   out_vid_reg;
    logic [RankBits-1:0]  out_rank_reg;
    logic [RankBits-1:0]  out_resid_reg;
    logic                 out_resched_reg;
    logic [CountBits-1:0] out_cnt_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                 in_xfer;
    logic                 cfg_wr;
    logic                 out_load;
    logic [CfgBits:0]     keep;
    logic [2*CfgBits-1:0] lo_prod;
    logic [AccBits:0]     acc_sum;
    logic [AccBits+1:0]   rank_sum;
    logic [AccBits-1:0]   base;
    logic [RankBits-1:0]  diff;
    logic [AccBits-1:0]   resid_q;

    prgau_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign cfg_wr      = psel && penable && pwrite;
    assign pready      = 1'b1;
    // the output register takes a new result once the previous one has left
    assign out_load    = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        unique case (paddr[2])
            RegResetProb[0]: prdata = restart_prob_reg;
            default:         prdata = accuracy_reg;
        endcase
    end

    assign keep     = (CfgBits+1)'(64'h1_0000_0000) - {1'b0, restart_prob_reg};
    assign base     = AccBits'(restart_prob_reg) << (RankFracDefault - CfgBits);
    assign lo_prod  = {32'b0, acc_reg[31:0]} * {31'b0, keep};
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, div_rsp.quotient};
    assign rank_sum = {2'b0, base} + {2'b0, prod_hi_reg}
                      + {26'b0, prod_lo_reg};
    assign diff     = (rank_new_reg >= last_rd_reg) ? rank_new_reg - last_rd_reg
                                                    : last_rd_reg - rank_new_reg;
    assign resid_q  = div_rsp.quotient;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = AccBits'(rank_rd_reg);
        div_req.divisor  = deg_reg;
        if (state_reg == S_GDIV)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == S_ADIV)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = AccBits'(diff);
        end
    end

    // memory write ports and registered reads
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            rank_mem[clr_reg] <= RankOne;
            last_mem[clr_reg] <= '0;
            cnt_mem[clr_reg]  <= '0;
        end
        else if (state_reg == S_ADIV)
        begin
            rank_mem[addr_reg] <= rank_new_reg;
            cnt_mem[addr_reg]  <= cnt_rd_reg + 1'b1;
        end
        else if (state_reg == S_AWAIT && div_rsp.done && resid_q > AccBits'(accuracy_reg))
        begin
            last_mem[addr_reg] <= rank_new_reg;
        end
        rank_rd_reg <= rank_mem[addr_reg];
        last_rd_reg <= last_mem[addr_reg];
        cnt_rd_reg  <= cnt_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            restart_prob_reg <= ResetProbDefault;
            accuracy_reg     <= AccuracyDefault;
            acc_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[1:0] == 2'b00)
            begin
                if (paddr[2] == RegResetProb[0])
                    restart_prob_reg <= pwdata;
                else
                    accuracy_reg <= pwdata;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AddrBits'(VERTEX_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        func_reg <= in_ch.func;
                        if (in_ch.func == FuncGather)
                        begin
                            addr_reg <= AddrBits'(in_ch.source_vertex);
                            deg_reg  <= in_ch.source_out_degree;
                        end
                        else
                        begin
                            addr_reg <= AddrBits'(in_ch.target_vertex);
                            deg_reg  <= in_ch.target_out_degree;
                        end
                        vid_reg   <= in_ch.target_vertex;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (func_reg == FuncGather)
                        state_reg <= (deg_reg == '0) ? S_IDLE : S_GDIV;
                    else
                        state_reg <= S_AMUL;
                end
                S_GDIV:
                    state_reg <= S_GWAIT;
                S_GWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        acc_reg   <= acc_sum[AccBits] ? AccMax : acc_sum[AccBits-1:0];
                        state_reg <= S_IDLE;
                    end
                end
                S_AMUL:
                begin
                    prod_hi_reg <= {32'b0, acc_reg[AccBits-1:32]} * {23'b0, keep};
                    prod_lo_reg <= lo_prod[2*CfgBits-1:CfgBits];
                    state_reg   <= S_ASUM;
                end
                S_ASUM:
                begin
                    rank_new_reg <= (rank_sum > (AccBits+2)'(RankMax)) ? RankMax
                                    : rank_sum[RankBits-1:0];
                    state_reg    <= S_ADIV;
                end
                S_ADIV:
                begin
                    res_cnt_reg <= cnt_rd_reg + 1'b1;
                    acc_reg     <= '0;
                    if (deg_reg == '0)
                    begin
                        res_resid_reg   <= '0;
                        res_resched_reg <= 1'b0;
                        state_reg       <= S_OUT;
                    end
                    else
                        state_reg <= S_AWAIT;
                end
                S_AWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        res_resid_reg   <= resid_q[RankBits-1:0];
                        res_resched_reg <= resid_q > AccBits'(accuracy_reg);
                        state_reg       <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_vid_reg     <= vid_reg;
                        out_rank_reg    <= rank_new_reg;
                        out_resid_reg   <= res_resid_reg;
                        out_resched_reg <= res_resched_reg;
                        out_cnt_reg     <= res_cnt_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.updated_vertex = out_vid_reg;
    assign out_ch.new_rank       = out_rank_reg;
    assign out_ch.residual       = out_resid_reg;
    assign out_ch.reschedule     = out_resched_reg;
    assign out_ch.update_count   = out_cnt_reg;

endmodule

// ===== design/prgau_checker.sv =====
// port-level checker for the pagerank gather/apply unit, bound to the top level
`include "assert_macros.svh"

module prgau_checker
    import prgau_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [RankBits-1:0]  out_residual,
    input logic                 out_reschedule,
    input logic                 pready
);

    // one item in flight: no new transfer right after an accepted one
    `CHK_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "input back to back")
    // a waiting result keeps its payload
    `CHK_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_residual), "moved")
    // zero residual never reschedules
    `CHK_IMPLY(a_resched, clk, rst_n, out_valid && out_reschedule, out_residual != '0, "resched")
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `CHK_IMPLY(a_pready, clk, rst_n, 1'b1, pready, "pready low")

endmodule

bind pagerank_gather_apply_unit prgau_checker u_prgau_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_residual   (out_ch.residual),
    .out_reschedule (out_ch.reschedule),
    .pready         (pready)
);

// ===== sim/prgau_rank_checker.sv =====
// checker for the pagerank gather/apply unit: predicts vertex updates and compares results
`timescale 1ns / 1ps

module prgau_rank_checker
    import prgau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    prgau_in_if                in_ch,
    prgau_out_if               out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [CfgBits-1:0] pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending,
    output int                 checked
);
    localparam logic [63:0] RankMax = (64'd1 << RankBits) - 64'd1;
    localparam logic [63:0] AccMax  = (64'd1 << AccBits) - 64'd1;

    typedef struct {
        logic [VidBits-1:0]   vid;
        logic [RankBits-1:0]  rank;
        logic [RankBits-1:0]  resid;
        logic                 resched;
        logic [CountBits-1:0] count;
    } vertex_update_t;

    vertex_update_t       expected_updates[$];
    logic [RankBits-1:0]  rank_mem [VertexCountDefault];
    logic [RankBits-1:0]  propagated_mem [VertexCountDefault];
    logic [CountBits-1:0] count_mem [VertexCountDefault];
    logic [AccBits-1:0]   rank_sum;
    logic [CfgBits-1:0]   restart_prob;
    logic [CfgBits-1:0]   accuracy;

    task automatic predict_item(input logic func, input logic [VidBits-1:0] src,
                                input logic [DegBits-1:0] src_deg,
                                input logic [VidBits-1:0] tgt,
                                input logic [DegBits-1:0] tgt_deg);
        logic [95:0]    prod;
        logic [63:0]    keep;
        logic [63:0]    rank;
        logic [63:0]    diff;
        logic [63:0]    share;
        vertex_update_t upd;
        if (func == FuncGather)
        begin
            if (src_deg != 0)
            begin
                share = {16'd0, rank_mem[src]} / {44'd0, src_deg};
                if (share > AccMax - {8'd0, rank_sum})
                    rank_sum = AccMax[AccBits-1:0];
                else
                    rank_sum = rank_sum + share[AccBits-1:0];
            end
        end
        else
        begin
            keep = (64'd1 << 32) - {32'd0, restart_prob};
            prod = {40'd0, rank_sum} * {32'd0, keep};
            rank = {32'd0, restart_prob} + prod[95:32];
            if (rank > RankMax)
                rank = RankMax;
            rank_mem[tgt] = rank[RankBits-1:0];
            count_mem[tgt] = count_mem[tgt] + 1;
            upd.vid = tgt;
            upd.rank = rank[RankBits-1:0];
            upd.resid = '0;
            upd.resched = 1'b0;
            upd.count = count_mem[tgt];
            if (tgt_deg != 0)
            begin
                diff = (rank >= {16'd0, propagated_mem[tgt]}) ?
                       rank - {16'd0, propagated_mem[tgt]} :
                       {16'd0, propagated_mem[tgt]} - rank;
                diff = diff / {44'd0, tgt_deg};
                upd.resid = diff[RankBits-1:0];
                if (diff > {32'd0, accuracy})
                begin
                    propagated_mem[tgt] = rank[RankBits-1:0];
                    upd.resched = 1'b1;
                end
            end
            expected_updates.push_back(upd);
            rank_sum = '0;
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        vertex_update_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < VertexCountDefault; i++)
            begin
                rank_mem[i] = 48'd1 << 32;
                propagated_mem[i] = '0;
                count_mem[i] = '0;
            end
            rank_sum = '0;
            restart_prob = ResetProbDefault;
            accuracy = AccuracyDefault;
            expected_updates.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                if ({1'b0, paddr[2]} == RegResetProb)
                    restart_prob = pwdata;
                else if ({1'b0, paddr[2]} == RegAccuracy)
                    accuracy = pwdata;
            end
            if (in_ch.valid && in_ch.ready)
                predict_item(in_ch.func, in_ch.source_vertex, in_ch.source_out_degree,
                             in_ch.target_vertex, in_ch.target_out_degree);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    $error("result transfer with no update expected (vertex %0h)",
                           out_ch.updated_vertex);
                    errors++;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    compare_field("updated_vertex", want.vid, out_ch.updated_vertex);
                    compare_field("new_rank", want.rank, out_ch.new_rank);
                    compare_field("residual", want.resid, out_ch.residual);
                    compare_field("reschedule", want.resched, out_ch.reschedule);
                    compare_field("update_count", want.count, out_ch.update_count);
                    checked++;
                end
            end
        end
        pending = expected_updates.size();
    end
endmodule

// ===== sim/testbench.sv =====
// testbench top: stimulus, configuration writes and verdict for the pagerank gather/apply unit
`timescale 1ns / 1ps

module testbench;
    import prgau_pkg::*;

    localparam int CycleLimit = 1500000;
    localparam int DrainCycles = 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [CfgBits-1:0] pwdata = '0;
    logic [CfgBits-1:0] prdata;
    logic               pready;
    int                 errors;
    int                 pending;
    int                 checked;
    int                 cycles = 0;
    int                 items_sent = 0;
    int                 settings_used = 0;
    bit                 calm = 1'b0;
    logic [VidBits-1:0] hot_vertex [8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd5,
                                           16'h7fff, 16'h8000, 16'hffff};

    prgau_in_if  in_ch (.clk(clk));
    prgau_out_if out_ch (.clk(clk));

    pagerank_gather_apply_unit DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    prgau_rank_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending),
        .checked(checked)
    );

    always #10 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.func = FuncGather;
        in_ch.source_vertex = '0;
        in_ch.source_out_degree = '0;
        in_ch.target_vertex = '0;
        in_ch.target_out_degree = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("** pagerank_gather_apply_unit: FAILED **");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (calm)
            out_ch.ready <= 1'b1;
        else if ($urandom_range(99) < 3)
            out_ch.ready <= 1'b0;
        else if (!out_ch.ready)
            out_ch.ready <= ($urandom_range(99) < 35);
        else
            out_ch.ready <= ($urandom_range(99) < 80);
    end

    task automatic send_item(input logic func, input logic [VidBits-1:0] src,
                             input logic [DegBits-1:0] src_deg,
                             input logic [VidBits-1:0] tgt,
                             input logic [DegBits-1:0] tgt_deg);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= func;
        in_ch.source_vertex <= src;
        in_ch.source_out_degree <= src_deg;
        in_ch.target_vertex <= tgt;
        in_ch.target_out_degree <= tgt_deg;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        items_sent++;
        if ($urandom_range(199) == 0)
            calm = !calm;
    endtask

    task automatic gather(input logic [VidBits-1:0] src, input logic [DegBits-1:0] deg);
        send_item(FuncGather, src, deg, VidBits'($urandom), DegBits'($urandom));
    endtask

    task automatic apply(input logic [VidBits-1:0] tgt, input logic [DegBits-1:0] deg);
        send_item(FuncApply, VidBits'($urandom), DegBits'($urandom), tgt, deg);
    endtask

    function automatic logic [DegBits-1:0] pick_degree();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 50)
            return DegBits'($urandom_range(4, 1));
        if (r < 60)
            return '1;
        if (r < 70)
            return DegBits'($urandom_range(64, 5));
        return DegBits'($urandom);
    endfunction

    function automatic logic [VidBits-1:0] pick_vertex();
        if ($urandom_range(99) < 70)
            return hot_vertex[$urandom_range(7)];
        return VidBits'($urandom);
    endfunction

    // both registers are written only with nothing in flight
    task automatic set_registers(input logic [CfgBits-1:0] prob,
                                 input logic [CfgBits-1:0] acc_thr);
        logic [CfgBits-1:0] vals [2];
        logic [1:0]         regs [2];
        vals = '{prob, acc_thr};
        regs = '{RegResetProb, RegAccuracy};
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        for (int i = 0; i < 2; i++)
        begin
            psel <= 1'b1;
            pwrite <= 1'b1;
            penable <= 1'b0;
            paddr <= {regs[i][0], 2'b00};
            pwdata <= vals[i];
            @(negedge clk);
            penable <= 1'b1;
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(negedge clk);
        end
        settings_used++;
    endtask

    task automatic random_phase(input int budget);
        int stop_at;
        int n;
        logic [VidBits-1:0] v;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            n = $urandom_range(99);
            if (n < 70)
            begin
                repeat ($urandom_range(8)) gather(pick_vertex(), pick_degree());
                apply(pick_vertex(), pick_degree());
            end
            else if (n < 78)
            begin
                // grow a rank by feeding a vertex back into itself
                v = hot_vertex[$urandom_range(7)];
                repeat ($urandom_range(40, 15)) gather(v, DegBits'(1));
                apply(v, pick_degree());
            end
            else if (n < 90)
                apply(pick_vertex(), pick_degree());
            else
                send_item(1'($urandom), VidBits'($urandom), DegBits'($urandom),
                          VidBits'($urandom), DegBits'($urandom));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_registers(ResetProbDefault, AccuracyDefault);

        // directed corners
        gather(16'd0, '0);
        gather(16'd0, DegBits'(1));
        gather(16'hffff, '1);
        apply(16'd0, '0);
        apply(16'd0, DegBits'(1));
        apply(16'd0, DegBits'(1));
        apply(16'hffff, '1);
        gather(16'h8000, DegBits'(3));
        gather(16'hffff, DegBits'(1));
        apply(16'h7fff, DegBits'(2));
        send_item(FuncGather, 16'hffff, '1, 16'hffff, '1);
        send_item(FuncApply, '0, '0, 16'h0001, '1);
        random_phase(280);

        set_registers('0, '0);
        // drive one vertex to saturation, then overflow the accumulator
        repeat (5)
        begin
            repeat (25) gather(16'd5, DegBits'(1));
            apply(16'd5, DegBits'(1));
        end
        repeat (300) gather(16'd5, DegBits'(1));
        apply(16'd5, '1);
        apply(16'd5, DegBits'(1));
        random_phase(150);

        set_registers('1, '1);
        random_phase(220);

        set_registers($urandom, $urandom_range(1000000));
        random_phase(220);

        set_registers(ResetProbDefault, AccuracyDefault);
        random_phase(100);

        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d input transfers and %0d apply results over %0d register settings",
                 items_sent, checked, settings_used);
        $display("corners: zero and full degrees, saturated rank and accumulator, extreme registers");
        if (errors == 0)
            $display("** pagerank_gather_apply_unit: PASSED **");
        else
            $display("** pagerank_gather_apply_unit: FAILED **");
        $finish;
    end
endmodule
